// ===== rtl/vrff_pkg.sv =====
// ----------------------------------------------------------------------------
// vrff_pkg
// Shared widths, codes and command/status types of the voxel ray face finder.
// ----------------------------------------------------------------------------
package vrff_pkg;

	localparam int GRID_BITS_DEF = 4;
	localparam int CELL_W = 8;      // signed cell index, covers the whole walk
	localparam int IDX_W = 4;       // cell index width on the ports
	localparam int POS_W = 16;
	localparam int DIR_W = 16;
	localparam int MAG_W = 16;
	localparam int EDGE_W = 17;     // distances and reach limits, Q.12
	localparam int PROD_W = EDGE_W + MAG_W;
	localparam int CFG_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int FACE_W = 3;
	localparam int IN_DATA_W = 112;
	localparam int OUT_DATA_W = 16;

	localparam logic [EDGE_W-1:0] CELL_ONE = EDGE_W'(4096);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EYE = 2'd3;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// Comparison slots of one walk step.
	localparam int CMP_W = 3;
	localparam logic [CMP_W-1:0] CMP_E01 = 3'd0;
	localparam logic [CMP_W-1:0] CMP_E02 = 3'd1;
	localparam logic [CMP_W-1:0] CMP_E12 = 3'd2;
	localparam logic [CMP_W-1:0] CMP_R0 = 3'd3;
	localparam logic [CMP_W-1:0] CMP_R1 = 3'd4;
	localparam logic [CMP_W-1:0] CMP_R2 = 3'd5;
	localparam int CMP_NUM = 6;

	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd0;
	localparam logic [FACE_W-1:0] FACE_TOP = 3'd1;
	localparam logic [FACE_W-1:0] FACE_NORTH = 3'd2;
	localparam logic [FACE_W-1:0] FACE_SOUTH = 3'd3;
	localparam logic [FACE_W-1:0] FACE_EAST = 3'd4;
	localparam logic [FACE_W-1:0] FACE_WEST = 3'd5;

	typedef struct packed {
		logic             clr_en;
		logic             wr_en;
		logic             load;
		logic             mul_a;
		logic             mul_b;
		logic [CMP_W-1:0] cmp_sel;
		logic             step;
		logic             res_load;
		logic             res_hit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_done;
		logic stop;
		logic hit;
	} dp_sts_t;

endpackage

// ===== rtl/vrff_datapath.sv =====
// ----------------------------------------------------------------------------
// vrff_datapath
// Occupancy memory, settings, ray state, shared multiplier and result fields.
// ----------------------------------------------------------------------------
module vrff_datapath import vrff_pkg::*; #(
	parameter int GRID_BITS = GRID_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [IDX_W-1:0]     cell_x,
	input  logic [IDX_W-1:0]     cell_y,
	input  logic [IDX_W-1:0]     cell_z,
	input  logic                 cell_filled,
	input  logic [POS_W-1:0]     origin_x,
	input  logic [POS_W-1:0]     origin_y,
	input  logic [POS_W-1:0]     origin_z,
	input  logic [DIR_W-1:0]     dir_x,
	input  logic [DIR_W-1:0]     dir_y,
	input  logic [DIR_W-1:0]     dir_z,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output logic                 found,
	output logic [IDX_W-1:0]     hit_x,
	output logic [IDX_W-1:0]     hit_y,
	output logic [IDX_W-1:0]     hit_z,
	output logic [FACE_W-1:0]    hit_face
);

	localparam int ADDR_W = 3 * GRID_BITS;
	localparam int DEPTH = 1 << ADDR_W;
	localparam int GRID_SIDE = 1 << GRID_BITS;

	logic [CFG_W-1:0] width_x_q, height_y_q, depth_z_q, eye_q;

	logic [ADDR_W:0]   clr_cnt_q;
	logic              mem_q [DEPTH];
	logic              mem_rd_q;
	logic [ADDR_W-1:0] waddr, raddr;

	logic [MAG_W-1:0]        mag_q   [3];
	logic                    neg_q   [3];
	logic [EDGE_W-1:0]       edge_q  [3];
	logic signed [CELL_W-1:0] cell_q [3];
	logic [EDGE_W-1:0]       reach_q [3];
	logic                    flag_q  [CMP_NUM];
	logic [PROD_W-1:0]       prod_q;

	logic [POS_W-1:0]        org [3];
	logic [DIR_W-1:0]        dir [3];
	logic [MAG_W-1:0]        mag_n   [3];
	logic                    neg_n   [3];
	logic [EDGE_W-1:0]       edge_n  [3];
	logic signed [CELL_W-1:0] cell_n [3];
	logic [EDGE_W-1:0]       reach_n [3];

	logic [1:0]         ax, ia, ib;
	logic               is_reach;
	logic [EDGE_W-1:0]  mx;
	logic [MAG_W-1:0]   my;
	logic [PROD_W-1:0]  mul_p;
	logic               flag_n;
	logic               in_grid;
	logic signed [18:0] up_reach;
	logic [FACE_W-1:0]  face_n;

	// Settings.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_x_q <= CFG_W'(2458);
			height_y_q <= CFG_W'(7373);
			depth_z_q <= CFG_W'(2458);
			eye_q <= CFG_W'(6636);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_WIDTH_X: width_x_q <= cfg_wdata;
				CFG_HEIGHT_Y: height_y_q <= cfg_wdata;
				CFG_DEPTH_Z: depth_z_q <= cfg_wdata;
				CFG_EYE: eye_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clearing pass counter; the top bit marks the pass as done.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr_en) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign waddr = {GRID_BITS'(cell_z), GRID_BITS'(cell_y), GRID_BITS'(cell_x)};
	assign raddr = {cell_q[2][GRID_BITS-1:0], cell_q[1][GRID_BITS-1:0],
		cell_q[0][GRID_BITS-1:0]};

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			mem_q[clr_cnt_q[ADDR_W-1:0]] <= 1'b0;
		end else if (cmd.wr_en) begin
			mem_q[waddr] <= cell_filled;
		end
		mem_rd_q <= mem_q[raddr];
	end

	// Ray set-up from the accepted item.
	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			neg_n[a] = dir[a][DIR_W-1];
			mag_n[a] = neg_n[a] ? MAG_W'(-dir[a]) : dir[a];
			cell_n[a] = CELL_W'(org[a][POS_W-1:12]);
			if (mag_n[a] == '0) begin
				edge_n[a] = CELL_ONE;
			end else if (!neg_n[a]) begin
				edge_n[a] = CELL_ONE - EDGE_W'(org[a][11:0]);
			end else if (org[a][11:0] != '0) begin
				edge_n[a] = EDGE_W'(org[a][11:0]);
			end else begin
				edge_n[a] = CELL_ONE;
				cell_n[a] = cell_n[a] - CELL_W'(1);
			end
		end
		up_reach = 19'sd16384 + $signed({3'b0, height_y_q, 1'b0})
			- $signed({4'b0, eye_q});
		reach_n[0] = (!neg_n[0] && mag_n[0] != '0)
			? EDGE_W'(16384) + EDGE_W'(width_x_q) : EDGE_W'(12288) + EDGE_W'(width_x_q);
		reach_n[1] = (!neg_n[1] && mag_n[1] != '0)
			? (up_reach[18] ? EDGE_W'(-up_reach) : EDGE_W'(up_reach))
			: EDGE_W'(12288) + EDGE_W'(eye_q);
		reach_n[2] = (!neg_n[2] && mag_n[2] != '0)
			? EDGE_W'(16384) + EDGE_W'(depth_z_q) : EDGE_W'(12288) + EDGE_W'(depth_z_q);
	end

	// Axis of the earliest crossing: x only if strictly first, then y only if strictly before z, else z.
	always_comb begin
		if (flag_q[0] && flag_q[1]) begin
			ax = AX_X;
		end else if (flag_q[2]) begin
			ax = AX_Y;
		end else begin
			ax = AX_Z;
		end
	end

	// Operand selection. Both sides of a compare go through the one multiplier,
	// the first product is held in prod_q.
	always_comb begin
		is_reach = 1'b0;
		unique case (cmd.cmp_sel)
			CMP_E01: begin ia = AX_X; ib = AX_Y; end
			CMP_E02: begin ia = AX_X; ib = AX_Z; end
			CMP_E12: begin ia = AX_Y; ib = AX_Z; end
			CMP_R0: begin ia = ax; ib = AX_X; is_reach = 1'b1; end
			CMP_R1: begin ia = ax; ib = AX_Y; is_reach = 1'b1; end
			CMP_R2: begin ia = ax; ib = AX_Z; is_reach = 1'b1; end
			default: begin ia = AX_X; ib = AX_X; end
		endcase
		if (cmd.mul_b) begin
			mx = is_reach ? reach_q[ib] : edge_q[ib];
			my = mag_q[ia];
		end else begin
			mx = edge_q[ia];
			my = mag_q[ib];
		end
		mul_p = PROD_W'(mx) * PROD_W'(my);
		if (is_reach) begin
			flag_n = (mag_q[ib] != '0) && (prod_q > mul_p);
		end else begin
			flag_n = (mag_q[ia] != '0) && ((mag_q[ib] == '0) || (prod_q < mul_p));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int a = 0; a < 3; a++) begin
				mag_q[a] <= mag_n[a];
				neg_q[a] <= neg_n[a];
				edge_q[a] <= edge_n[a];
				cell_q[a] <= cell_n[a];
				reach_q[a] <= reach_n[a];
			end
		end else if (cmd.step) begin
			cell_q[ax] <= neg_q[ax] ? cell_q[ax] - CELL_W'(1) : cell_q[ax] + CELL_W'(1);
			edge_q[ax] <= edge_q[ax] + CELL_ONE;
		end
		if (cmd.mul_a) begin
			prod_q <= mul_p;
		end
		if (cmd.mul_b) begin
			flag_q[cmd.cmp_sel] <= flag_n;
		end
	end

	always_comb begin
		in_grid = 1'b1;
		for (int a = 0; a < 3; a++) begin
			if (cell_q[a][CELL_W-1] || (cell_q[a][CELL_W-2:0] >= (CELL_W-1)'(GRID_SIDE))) begin
				in_grid = 1'b0;
			end
		end
		unique case (ax)
			AX_X: face_n = neg_q[0] ? FACE_EAST : FACE_WEST;
			AX_Y: face_n = neg_q[1] ? FACE_TOP : FACE_BOTTOM;
			default: face_n = neg_q[2] ? FACE_NORTH : FACE_SOUTH;
		endcase
	end

	assign sts.clr_done = clr_cnt_q[ADDR_W];
	assign sts.stop = (mag_q[ax] == '0) || flag_q[3] || flag_q[4] || flag_q[5];
	assign sts.hit = in_grid && mem_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			found <= cmd.res_hit;
			hit_x <= cmd.res_hit ? cell_q[0][IDX_W-1:0] : '0;
			hit_y <= cmd.res_hit ? cell_q[1][IDX_W-1:0] : '0;
			hit_z <= cmd.res_hit ? cell_q[2][IDX_W-1:0] : '0;
			hit_face <= cmd.res_hit ? face_n : FACE_BOTTOM;
		end
	end

endmodule

// ===== rtl/vrff_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrff_ctrl
// Controller: clearing pass, handshakes and the walk sequence of one ray.
// ----------------------------------------------------------------------------
module vrff_ctrl import vrff_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    command,
	output logic    m_tvalid,
	input  logic    m_tready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MULA = 3'd2;
	localparam logic [2:0] S_MULB = 3'd3;
	localparam logic [2:0] S_STEP = 3'd4;
	localparam logic [2:0] S_RD = 3'd5;
	localparam logic [2:0] S_TEST = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]       state_q;
	logic [CMP_W-1:0] cmp_q;
	logic             hit_q;
	logic             m_tvalid_q;
	logic             accept;
	logic             out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		cmd = '0;
		cmd.clr_en = (state_q == S_CLEAR) && !sts.clr_done;
		cmd.wr_en = accept && (command == CMD_WRITE);
		cmd.load = accept && (command == CMD_CAST);
		cmd.mul_a = (state_q == S_MULA);
		cmd.mul_b = (state_q == S_MULB);
		cmd.cmp_sel = cmp_q;
		cmd.step = (state_q == S_STEP) && !sts.stop;
		cmd.res_load = (state_q == S_DONE) && out_free;
		cmd.res_hit = hit_q;
	end

	// Result valid: set when a finished ray is presented, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cmp_q <= CMP_E01;
			hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && command == CMD_CAST) begin
						cmp_q <= CMP_E01;
						hit_q <= 1'b0;
						state_q <= S_MULA;
					end
				end
				S_MULA: state_q <= S_MULB;
				S_MULB: begin
					if (cmp_q == CMP_R2) begin
						state_q <= S_STEP;
					end else begin
						cmp_q <= cmp_q + 1'b1;
						state_q <= S_MULA;
					end
				end
				S_STEP: begin
					state_q <= sts.stop ? S_DONE : S_RD;
				end
				S_RD: state_q <= S_TEST;
				S_TEST: begin
					if (sts.hit) begin
						hit_q <= 1'b1;
						state_q <= S_DONE;
					end else begin
						cmp_q <= CMP_E01;
						state_q <= S_MULA;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && !sts.clr_done) |=> (state_q == S_CLEAR))
		else $error("clearing pass left early");
	a_mul_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MULA) |=> (state_q == S_MULB && $stable(cmp_q)))
		else $error("compare slot changed between its two products");
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (state_q == S_IDLE && m_tvalid_q))
		else $error("result not presented when the output was free");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while a ray is in flight");
`endif

endmodule

// ===== rtl/voxel_ray_face_finder_top.sv =====
// A ray walks in steps: each step makes six compares through one shared multiplier,
//   two products per compare, then the step, the memory read and the hit test. The
//   result is presented once a hit is found or the walk stops; the reach allows at most
//   44 steps. Throughput: one ray at a time.
// Reset: settings take their defaults and a clearing pass over all 2^(3*GRID_BITS) cells
//   empties the grid before the first item is taken.
// ----------------------------------------------------------------------------
// voxel_ray_face_finder_top
// Finds the first filled voxel along a view ray and the face it is entered by.
// ----------------------------------------------------------------------------
module voxel_ray_face_finder_top import vrff_pkg::*; #(
	parameter int GRID_BITS = GRID_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Settings write port; the index follows the register list.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_W-1:0]      cfg_wdata,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata from bit 0: cell_x, cell_y, cell_z, cell_filled, origin_x,
	// origin_y, origin_z, dir_x, dir_y, dir_z, zero padding.
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: command (0 writes a cell, 1 casts a ray).
	input  logic                  s_tuser,
	// Output stream, one transaction per cast.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata from bit 0: found, hit_x, hit_y, hit_z, hit_face.
	output logic [OUT_DATA_W-1:0] m_tdata
);

	dp_cmd_t            cmd;
	dp_sts_t            sts;
	logic               found;
	logic [IDX_W-1:0]   hit_x, hit_y, hit_z;
	logic [FACE_W-1:0]  hit_face;

	// The controller owns all handshakes and sequencing; the datapath holds the
	// grid, settings, ray state and the result fields.
	vrff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.command  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	vrff_datapath #(
		.GRID_BITS (GRID_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.cell_x      (s_tdata[3:0]),
		.cell_y      (s_tdata[7:4]),
		.cell_z      (s_tdata[11:8]),
		.cell_filled (s_tdata[12]),
		.origin_x    (s_tdata[28:13]),
		.origin_y    (s_tdata[44:29]),
		.origin_z    (s_tdata[60:45]),
		.dir_x       (s_tdata[76:61]),
		.dir_y       (s_tdata[92:77]),
		.dir_z       (s_tdata[108:93]),
		.cmd         (cmd),
		.sts         (sts),
		.found       (found),
		.hit_x       (hit_x),
		.hit_y       (hit_y),
		.hit_z       (hit_z),
		.hit_face    (hit_face)
	);

	assign m_tdata = {hit_face, hit_z, hit_y, hit_x, found};

endmodule
